// ===== rtl/i32dr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i32dr_pkg;

   localparam int DATA_WIDTH = 32;
   // one restoring step per pipeline stage
   localparam int STEPS = DATA_WIDTH;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // nq holds the numerator bits still to shift in (top) and the quotient bits so far (bottom)
   typedef struct packed {
      word_type nq;
      word_type rem;
      word_type den;
      logic     neg_q;
      logic     neg_r;
   } stage_type;

endpackage

`default_nettype wire

// ===== rtl/i32dr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface i32dr_req_if import i32dr_pkg::*;;
   logic     valid;
   logic     ready;
   word_type numerator;
   word_type denominator;
   logic     func;

   modport source (output valid, numerator, denominator, func, input ready);
   modport sink   (input valid, numerator, denominator, func, output ready);
endinterface

interface i32dr_rsp_if import i32dr_pkg::*;;
   logic     valid;
   logic     ready;
   word_type quotient;
   word_type remainder;

   modport source (output valid, quotient, remainder, input ready);
   modport sink   (input valid, quotient, remainder, output ready);
endinterface

`default_nettype wire

// ===== rtl/i32dr_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i32dr_step import i32dr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      in_valid,
   input  stage_type in_stage,
   output logic      out_valid,
   output stage_type out_stage
);

   logic                  valid_ff;
   stage_type             stage_ff;
   stage_type             stage_in;
   logic                  in_bit;
   logic                  over;
   word_type              shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;

   // shift in one numerator bit, trial subtract, keep on no borrow
   always_comb begin
      in_bit  = in_stage.nq[DATA_WIDTH-1];
      over    = in_stage.rem[DATA_WIDTH-1];
      shifted = {in_stage.rem[DATA_WIDTH-2:0], in_bit};
      diff    = {over, shifted} - {1'b0, in_stage.den};
      take    = ~diff[DATA_WIDTH];
      stage_in       = in_stage;
      stage_in.nq    = {in_stage.nq[DATA_WIDTH-2:0], take};
      stage_in.rem   = take ? diff[DATA_WIDTH-1:0] : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/int32_divide_remainder_core.sv =====
// rsp.valid rises once an accepted req transaction has passed the front stage, 32 step stages
// and the output register. Throughput: one division per cycle while rsp.ready does not stall
// the pipe; 32 trial-subtract stages, one quotient bit each.
// A one-entry input skid register keeps req.ready off the rsp.ready path.
// Reset (synchronous, active high) clears the skid, all stage valid bits and rsp.valid;
// data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module int32_divide_remainder_core import i32dr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i32dr_req_if.sink   req,
   i32dr_rsp_if.source rsp
);

   // global advance: the whole pipe moves when the output register is free
   logic advance;

   // input skid
   logic     skid_valid_ff;
   word_type skid_num_ff;
   word_type skid_den_ff;
   logic     skid_func_ff;

   // selected source for the front stage
   logic     src_valid;
   word_type src_num;
   word_type src_den;
   logic     src_func;

   // front stage: magnitudes and sign fix-up flags
   logic      num_neg;
   logic      den_neg;
   logic      den_zero;
   stage_type front_in;
   stage_type front_ff;
   logic      front_valid_ff;

   // step chain; index 0 is the front stage
   logic      stage_valid [STEPS+1];
   stage_type stage_data  [STEPS+1];

   // output register
   logic      out_valid_ff;
   word_type  out_quot_ff;
   word_type  out_rem_ff;
   word_type  quot_in;
   word_type  rem_in;
   stage_type last;

   assign advance   = ~out_valid_ff | rsp.ready;
   assign req.ready = ~skid_valid_ff;

   // hold a transaction in the skid when the pipe is stalled; drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && !advance) begin
         skid_num_ff  <= req.numerator;
         skid_den_ff  <= req.denominator;
         skid_func_ff <= req.func;
      end
   end

   always_comb begin
      src_valid = skid_valid_ff | req.valid;
      src_num   = skid_valid_ff ? skid_num_ff  : req.numerator;
      src_den   = skid_valid_ff ? skid_den_ff  : req.denominator;
      src_func  = skid_valid_ff ? skid_func_ff : req.func;
   end

   // Signed mode divides magnitudes. A zero divisor keeps the quotient positive
   // (all ones) while the remainder sign fix-up turns the magnitude back into
   // the numerator itself.
   always_comb begin
      num_neg  = src_func & src_num[DATA_WIDTH-1];
      den_neg  = src_func & src_den[DATA_WIDTH-1];
      den_zero = (src_den == '0);
      front_in.nq    = num_neg ? (~src_num) + word_type'(1) : src_num;
      front_in.den   = den_neg ? (~src_den) + word_type'(1) : src_den;
      front_in.rem   = '0;
      front_in.neg_q = (num_neg ^ den_neg) & ~den_zero;
      front_in.neg_r = num_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff <= front_in;
      end
   end

   assign stage_valid[0] = front_valid_ff;
   assign stage_data[0]  = front_ff;

   // one quotient bit per stage, MSB first
   genvar g;
   for (g = 0; g < STEPS; g++) begin : g_step
      i32dr_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (stage_valid[g]),
         .in_stage  (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_stage (stage_data[g+1])
      );
   end

   // apply the sign fix-ups on the way into the output register
   always_comb begin
      last    = stage_data[STEPS];
      quot_in = last.neg_q ? (~last.nq)  + word_type'(1) : last.nq;
      rem_in  = last.neg_r ? (~last.rem) + word_type'(1) : last.rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_quot_ff <= quot_in;
         out_rem_ff  <= rem_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.quotient  = out_quot_ff;
   assign rsp.remainder = out_rem_ff;

endmodule

`default_nettype wire

// ===== rtl/i32dr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i32dr_checker import i32dr_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input word_type rsp_quotient,
   input word_type rsp_remainder
);

   // skid + front stage + step stages + output register
   localparam int CAPACITY = STEPS + 3;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic             req_fire;
   logic             rsp_fire;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_ff + CNT_W'(req_fire) - CNT_W'(rsp_fire);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient) && $stable(rsp_remainder))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("rsp transaction without an outstanding req");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(CAPACITY) |-> !req_ready)
      else $error("req accepted with pipeline full");

endmodule

bind int32_divide_remainder_core i32dr_checker u_i32dr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_quotient  (rsp.quotient),
   .rsp_remainder (rsp.remainder)
);

`default_nettype wire
